@@ rtl/tdq_pkg.sv @@
// Shared types, field widths and codes for the timer deadline queue.
// Used by the entry RAM and the queue core; depends on nothing else.

package tdq_pkg;

	localparam int DL_W         = 48;
	localparam int ID_W         = 16;
	localparam int CAPACITY_DEF = 16;
	localparam int MAX_OUT      = 16;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 72;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_EXPIRE = 1'b1;

	localparam logic [1:0] KIND_INSERT  = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_NONE    = 2'd2;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_DUP  = 2'd2;

	typedef struct packed {
		logic [DL_W-1:0] deadline;
		logic [ID_W-1:0] id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// True when pair a sorts strictly before pair b: by deadline, then by id.
	function automatic logic pair_less(entry_t a, entry_t b);
		return (a.deadline < b.deadline) ||
			((a.deadline == b.deadline) && (a.id < b.id));
	endfunction

endpackage

@@ rtl/timer_deadline_queue_core.sv @@
// Timer deadline queue: a sorted table of (deadline, id) pairs in one RAM,
// driven by a read-modify-write sequencer. Depends on tdq_pkg and tdq_ram.

// The queue holds up to CAPACITY timers sorted by deadline, then by id, in a
// single entry RAM; only entries below the fill count are ever read, so there
// is no clearing pass after reset. One request is handled at a time. Each RAM
// step issues a read in one cycle and uses the data in the next. An insert
// scans down from the tail to its slot and then shifts the later entries up.
// An expire scans the due entries (at most 16), reports them and moves the
// rest down, and it waits while the output is stalled. A result waits in an
// output register, and the next request is taken while it waits.

module timer_deadline_queue_core
	import tdq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// time_value [47:0], timer_id [63:48]
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// cmd [0]
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out_id [15:0], out_deadline [63:16], is_earliest [64], status [66:65]
	output logic [OUT_TDATA_W-1:0] m_tdata,
	// kind [1:0]
	output logic [1:0]             m_tuser,
	output logic                   m_tlast
);

	localparam int AW      = $clog2(CAPACITY);
	localparam int CW      = $clog2(CAPACITY + 1);
	localparam int OUT_LIM = (MAX_OUT < CAPACITY) ? MAX_OUT : CAPACITY;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_ISCAN_RD  = 4'd1;
	localparam logic [3:0] ST_ISCAN_CMP = 4'd2;
	localparam logic [3:0] ST_ISHIFT_RD = 4'd3;
	localparam logic [3:0] ST_ISHIFT_WR = 4'd4;
	localparam logic [3:0] ST_IWRITE    = 4'd5;
	localparam logic [3:0] ST_REPLY     = 4'd6;
	localparam logic [3:0] ST_XSCAN_RD  = 4'd7;
	localparam logic [3:0] ST_XSCAN_CMP = 4'd8;
	localparam logic [3:0] ST_XEMIT_RD  = 4'd9;
	localparam logic [3:0] ST_XEMIT_OUT = 4'd10;
	localparam logic [3:0] ST_XMOVE_RD  = 4'd11;
	localparam logic [3:0] ST_XMOVE_WR  = 4'd12;
	localparam logic [3:0] ST_NONE      = 4'd13;

	logic [3:0]      state_q;
	logic [AW-1:0]   idx_q;
	logic [AW-1:0]   pos_q;
	logic [CW-1:0]   n_q;
	logic [CW-1:0]   count_q;
	logic [DL_W-1:0] tv_q;
	logic [ID_W-1:0] id_q;
	logic            early_q;
	logic [1:0]      status_q;

	logic            out_valid_q;
	logic [1:0]      out_kind_q;
	logic [ID_W-1:0] out_id_q;
	logic [DL_W-1:0] out_dl_q;
	logic            out_early_q;
	logic [1:0]      out_status_q;
	logic            out_last_q;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	entry_t        rd_entry;
	entry_t        new_entry;
	logic          less_c;
	logic          same_c;
	logic          due_c;
	logic          slot_free;
	logic          out_load;
	logic [CW-1:0] idx_p1_c;

	tdq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_entry  = entry_t'(ram_rdata);
	assign new_entry = '{deadline: tv_q, id: id_q};
	assign less_c    = pair_less(new_entry, rd_entry);
	assign same_c    = (rd_entry == new_entry);
	assign due_c     = (rd_entry.deadline <= tv_q);
	assign slot_free = !out_valid_q || m_tready;
	assign idx_p1_c  = CW'(idx_q) + CW'(1);
	assign out_load  = slot_free && ((state_q == ST_REPLY) || (state_q == ST_XEMIT_OUT) ||
		(state_q == ST_NONE));

	// Reads and writes fall in separate states, so an entry is never read in
	// the cycle it is written and no forwarding is needed.
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		unique case (state_q)
			ST_ISCAN_RD, ST_XSCAN_RD, ST_XEMIT_RD, ST_XMOVE_RD: begin
				ram_re = 1'b1;
			end
			ST_ISHIFT_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q - AW'(1);
			end
			ST_ISHIFT_WR: begin
				ram_we = 1'b1;
			end
			ST_IWRITE: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = new_entry;
			end
			ST_XMOVE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(CW'(idx_q) - n_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			pos_q        <= '0;
			n_q          <= '0;
			count_q      <= '0;
			tv_q         <= '0;
			id_q         <= '0;
			early_q      <= 1'b0;
			status_q     <= STATUS_OK;
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_INSERT;
			out_id_q     <= '0;
			out_dl_q     <= '0;
			out_early_q  <= 1'b0;
			out_status_q <= STATUS_OK;
			out_last_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						tv_q     <= s_tdata[DL_W-1:0];
						id_q     <= s_tdata[DL_W+ID_W-1:DL_W];
						status_q <= STATUS_OK;
						early_q  <= (count_q == '0);
						n_q      <= '0;
						if (s_tuser == CMD_INSERT) begin
							if (count_q == '0) begin
								pos_q   <= '0;
								state_q <= ST_IWRITE;
							end else begin
								idx_q   <= AW'(count_q - CW'(1));
								state_q <= ST_ISCAN_RD;
							end
						end else begin
							if (count_q == '0) begin
								state_q <= ST_NONE;
							end else begin
								idx_q   <= '0;
								state_q <= ST_XSCAN_RD;
							end
						end
					end
				end
				ST_ISCAN_RD: begin
					state_q <= ST_ISCAN_CMP;
				end
				ST_ISCAN_CMP: begin
					if (less_c && (idx_q != '0)) begin
						idx_q   <= idx_q - AW'(1);
						state_q <= ST_ISCAN_RD;
					end else begin
						// The slot is found; the duplicate check wins over the full check.
						priority if (same_c) begin
							status_q <= STATUS_DUP;
							early_q  <= 1'b0;
							state_q  <= ST_REPLY;
						end else if (count_q == CW'(CAPACITY)) begin
							status_q <= STATUS_FULL;
							early_q  <= 1'b0;
							state_q  <= ST_REPLY;
						end else if (less_c) begin
							// New head; a tie on the deadline does not move the alarm.
							pos_q   <= '0;
							early_q <= (tv_q < rd_entry.deadline);
							idx_q   <= AW'(count_q);
							state_q <= ST_ISHIFT_RD;
						end else begin
							pos_q   <= AW'(idx_p1_c);
							early_q <= 1'b0;
							if (idx_p1_c == count_q) begin
								state_q <= ST_IWRITE;
							end else begin
								idx_q   <= AW'(count_q);
								state_q <= ST_ISHIFT_RD;
							end
						end
					end
				end
				ST_ISHIFT_RD: begin
					state_q <= ST_ISHIFT_WR;
				end
				ST_ISHIFT_WR: begin
					if ((idx_q - AW'(1)) == pos_q) begin
						state_q <= ST_IWRITE;
					end else begin
						idx_q   <= idx_q - AW'(1);
						state_q <= ST_ISHIFT_RD;
					end
				end
				ST_IWRITE: begin
					count_q <= count_q + CW'(1);
					state_q <= ST_REPLY;
				end
				ST_REPLY: begin
					if (slot_free) begin
						out_kind_q   <= KIND_INSERT;
						out_id_q     <= id_q;
						out_dl_q     <= tv_q;
						out_early_q  <= early_q;
						out_status_q <= status_q;
						out_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				ST_XSCAN_RD: begin
					state_q <= ST_XSCAN_CMP;
				end
				ST_XSCAN_CMP: begin
					if (due_c) begin
						n_q <= idx_p1_c;
						if ((idx_p1_c == count_q) || (idx_p1_c == CW'(OUT_LIM))) begin
							idx_q   <= '0;
							state_q <= ST_XEMIT_RD;
						end else begin
							idx_q   <= AW'(idx_p1_c);
							state_q <= ST_XSCAN_RD;
						end
					end else if (n_q == '0) begin
						state_q <= ST_NONE;
					end else begin
						idx_q   <= '0;
						state_q <= ST_XEMIT_RD;
					end
				end
				ST_XEMIT_RD: begin
					state_q <= ST_XEMIT_OUT;
				end
				ST_XEMIT_OUT: begin
					// Read data holds while the output is stalled.
					if (slot_free) begin
						out_kind_q   <= KIND_EXPIRED;
						out_id_q     <= rd_entry.id;
						out_dl_q     <= rd_entry.deadline;
						out_early_q  <= 1'b0;
						out_status_q <= STATUS_OK;
						out_last_q   <= (idx_p1_c == n_q);
						if (idx_p1_c == n_q) begin
							if (n_q == count_q) begin
								count_q <= '0;
								state_q <= ST_IDLE;
							end else begin
								idx_q   <= AW'(n_q);
								state_q <= ST_XMOVE_RD;
							end
						end else begin
							idx_q   <= AW'(idx_p1_c);
							state_q <= ST_XEMIT_RD;
						end
					end
				end
				ST_XMOVE_RD: begin
					state_q <= ST_XMOVE_WR;
				end
				ST_XMOVE_WR: begin
					if (idx_p1_c == count_q) begin
						count_q <= count_q - n_q;
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= AW'(idx_p1_c);
						state_q <= ST_XMOVE_RD;
					end
				end
				ST_NONE: begin
					if (slot_free) begin
						out_kind_q   <= KIND_NONE;
						out_id_q     <= '0;
						out_dl_q     <= '0;
						out_early_q  <= 1'b0;
						out_status_q <= STATUS_OK;
						out_last_q   <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(OUT_TDATA_W - DL_W - ID_W - 3)'(0), out_status_q, out_early_q,
		out_dl_q, out_id_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_ram_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("entry RAM read and written in the same cycle");

	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_NONE)) |-> ((m_tdata == '0) && m_tlast))
		else $error("nothing-expired result carries data or lacks last");

endmodule

@@ rtl/tdq_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on tdq_pkg for its default sizes only.

module tdq_ram
	import tdq_pkg::*;
#(
	parameter int WIDTH = ENTRY_W,
	parameter int DEPTH = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ verif/timer_deadline_queue_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for timer_deadline_queue_core: directed and random insert
// and expire requests, each checked against an in-bench model of the sorted timer table.
// Depends on tdq_pkg and the queue core RTL.

module timer_deadline_queue_core_tb;
	import tdq_pkg::*;

	localparam int QUEUE_DEPTH  = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 250;
	localparam int DRAIN_CYCLES = 4 * QUEUE_DEPTH + 40;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 400;
	localparam logic [DL_W-1:0] DL_MAX = '1;
	localparam logic [ID_W-1:0] ID_MAX = '1;

	typedef struct {
		logic [1:0]      kind;
		logic [ID_W-1:0] id;
		logic [DL_W-1:0] deadline;
		logic            early;
		logic [1:0]      status;
		logic            last;
	} reply_t;

	typedef struct {
		logic            cmd;
		logic [DL_W-1:0] tv;
		logic [ID_W-1:0] id;
		bit              typed;
		logic [1:0]      kind;
		logic [1:0]      status;
		logic            early;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]             m_tuser;
	logic                   m_tlast;

	entry_t    timer_table[QUEUE_DEPTH];
	int        table_count;
	reply_t    step_replies[$];
	reply_t    pending_results[$];
	stim_row_t stim_rows[$];
	int        mismatches;
	int        results_seen;
	int        cycle_count;

	timer_deadline_queue_core #(
		.CAPACITY(QUEUE_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Sorted table update for one request; the replies it causes go to step_replies.
	function automatic void apply_to_timer_table(logic cmd, logic [DL_W-1:0] tv,
			logic [ID_W-1:0] id);
		int pos;
		int n;
		reply_t r;
		step_replies.delete();
		if (cmd == CMD_INSERT) begin
			r = '{KIND_INSERT, id, tv, 1'b0, STATUS_OK, 1'b1};
			pos = 0;
			while (pos < table_count && (timer_table[pos].deadline < tv ||
					(timer_table[pos].deadline == tv && timer_table[pos].id < id)))
				pos++;
			// The duplicate check wins over the full check.
			if (pos < table_count && timer_table[pos].deadline == tv &&
					timer_table[pos].id == id) begin
				r.status = STATUS_DUP;
			end else if (table_count >= QUEUE_DEPTH) begin
				r.status = STATUS_FULL;
			end else begin
				r.early = (table_count == 0) || (tv < timer_table[0].deadline);
				for (int i = table_count; i > pos; i--)
					timer_table[i] = timer_table[i-1];
				timer_table[pos].deadline = tv;
				timer_table[pos].id = id;
				table_count++;
			end
			step_replies.push_back(r);
		end else begin
			n = 0;
			while (n < table_count && n < MAX_OUT && timer_table[n].deadline <= tv)
				n++;
			if (n == 0)
				step_replies.push_back('{KIND_NONE, '0, '0, 1'b0, STATUS_OK, 1'b1});
			for (int i = 0; i < n; i++)
				step_replies.push_back('{KIND_EXPIRED, timer_table[i].id,
					timer_table[i].deadline, 1'b0, STATUS_OK, (i == n - 1)});
			for (int i = n; i < table_count; i++)
				timer_table[i-n] = timer_table[i];
			table_count -= n;
		end
	endfunction

	function automatic void add_row(logic cmd, logic [DL_W-1:0] tv, logic [ID_W-1:0] id,
			bit typed, logic [1:0] kind, logic [1:0] status, logic early);
		stim_rows.push_back('{cmd, tv, id, typed, kind, status, early});
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Drives one request and holds it until the core takes it.
	task automatic send_request(input stim_row_t row);
		reply_t r;
		s_tvalid <= 1'b1;
		s_tuser  <= row.cmd;
		s_tdata  <= {row.id, row.tv};
		do @(posedge clk); while (s_tready !== 1'b1);
		apply_to_timer_table(row.cmd, row.tv, row.id);
		if (row.typed) begin
			r = '{row.kind, '0, '0, row.early, row.status, 1'b1};
			if (row.kind == KIND_INSERT) begin
				r.id = row.id;
				r.deadline = row.tv;
			end
			pending_results.push_back(r);
		end else begin
			foreach (step_replies[i])
				pending_results.push_back(step_replies[i]);
		end
	endtask

	task automatic sender_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		reply_t want;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			results_seen <= results_seen + 1;
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: kind 0x%0h id 0x%0h",
					m_tuser, m_tdata[15:0]);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				check_field("kind", 64'(want.kind), 64'(m_tuser));
				check_field("out_id", 64'(want.id), 64'(m_tdata[15:0]));
				check_field("out_deadline", 64'(want.deadline), 64'(m_tdata[63:16]));
				check_field("is_earliest", 64'(want.early), 64'(m_tdata[64]));
				check_field("status", 64'(want.status), 64'(m_tdata[66:65]));
				check_field("last", 64'(want.last), 64'(m_tlast));
			end
		end
	end

	// Receiver: random stalls, and one long hold-off so that the core backs up.
	initial begin
		int r;
		int n;
		bit held;
		held = 1'b0;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held && results_seen >= 60) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			r = $urandom_range(0, 99);
			n = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(15, 60);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ((r < 10) ? $urandom_range(20, 60) : $urandom_range(1, 4)) @(posedge clk);
		end
	end

	initial begin
		stim_row_t row;
		logic [DL_W-1:0] now_us;
		entry_t pick;
		int r;
		int s;
		bit heavy;
		mismatches = 0;
		results_seen = 0;
		cycle_count = 0;
		table_count = 0;
		now_us = '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_INSERT;
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(CMD_EXPIRE, '0, '0, 1'b1, KIND_NONE, STATUS_OK, 1'b0);
		add_row(CMD_EXPIRE, DL_MAX, ID_MAX, 1'b1, KIND_NONE, STATUS_OK, 1'b0);
		add_row(CMD_INSERT, DL_MAX, ID_MAX, 1'b1, KIND_INSERT, STATUS_OK, 1'b1);
		add_row(CMD_INSERT, DL_MAX, ID_MAX, 1'b1, KIND_INSERT, STATUS_DUP, 1'b0);
		add_row(CMD_INSERT, '0, '0, 1'b1, KIND_INSERT, STATUS_OK, 1'b1);
		// Ties with the head deadline, then the same id with another deadline.
		add_row(CMD_INSERT, '0, 16'd5, 1'b0, KIND_INSERT, STATUS_OK, 1'b0);
		add_row(CMD_INSERT, DL_MAX, '0, 1'b0, KIND_INSERT, STATUS_OK, 1'b0);
		add_row(CMD_INSERT, 48'd100, ID_MAX, 1'b0, KIND_INSERT, STATUS_OK, 1'b0);
		add_row(CMD_EXPIRE, '0, 16'h1234, 1'b0, KIND_NONE, STATUS_OK, 1'b0);
		for (int i = 0; i < QUEUE_DEPTH - 3; i++)
			add_row(CMD_INSERT, 48'd200 + 7 * i, 16'hA5A5 ^ i[15:0], 1'b0, KIND_INSERT,
				STATUS_OK, 1'b0);
		// The table is full here: a new pair is dropped, a known pair is a duplicate.
		add_row(CMD_INSERT, 48'd50, 16'd1, 1'b1, KIND_INSERT, STATUS_FULL, 1'b0);
		add_row(CMD_INSERT, DL_MAX, ID_MAX, 1'b1, KIND_INSERT, STATUS_DUP, 1'b0);
		add_row(CMD_EXPIRE, DL_MAX, '0, 1'b0, KIND_NONE, STATUS_OK, 1'b0);
		add_row(CMD_EXPIRE, DL_MAX, '0, 1'b1, KIND_NONE, STATUS_OK, 1'b0);

		foreach (stim_rows[k]) begin
			sender_gap();
			send_request(stim_rows[k]);
		end
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		@(posedge clk);

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			// Alternate between insert-heavy stretches that fill the table and mixed ones.
			heavy = ((k / 40) % 2) == 0;
			r = $urandom_range(0, 99);
			s = $urandom_range(0, 99);
			row = '{CMD_INSERT, '0, '0, 1'b0, KIND_INSERT, STATUS_OK, 1'b0};
			if (r < (heavy ? 85 : 55)) begin
				if (s < 10 && table_count > 0) begin
					pick = timer_table[$urandom_range(0, table_count - 1)];
					row.tv = pick.deadline;
					row.id = pick.id;
				end else begin
					row.tv = now_us + $urandom_range(0, 200);
					if (s >= 96)
						row.tv = DL_W'({$urandom, $urandom});
					else if (s == 95)
						row.tv = DL_MAX;
					row.id = ($urandom_range(0, 4) == 0) ? ID_W'($urandom)
						: ID_W'($urandom_range(0, 31));
				end
			end else begin
				row.cmd = CMD_EXPIRE;
				now_us = now_us + $urandom_range(0, 150);
				row.tv = now_us;
				if (s < 3)
					row.tv = DL_W'({$urandom, $urandom});
				else if (s == 3)
					row.tv = DL_MAX;
				row.id = ID_W'($urandom);
			end
			if (k == RANDOM_ITEMS / 2) begin
				s_tvalid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
				@(posedge clk);
			end else begin
				sender_gap();
			end
			send_request(row);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ files.f @@
rtl/tdq_pkg.sv
rtl/tdq_ram.sv
rtl/timer_deadline_queue_core.sv
verif/timer_deadline_queue_core_tb.sv
